// ===== rtl/core/priority_ready_queue_defines.svh =====
// Assertion macros for the ready queue
`ifndef PRIORITY_READY_QUEUE_DEFINES_SVH
`define PRIORITY_READY_QUEUE_DEFINES_SVH

// Check on every clock edge, off while reset is held
`define PRQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check on every clock edge, including reset
`define PRQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/prq_pkg.sv =====
package prq_pkg;

  localparam int DEPTH     = 16;
  localparam int PID_BITS  = 4;
  localparam int PRIO_BITS = 8;
  localparam int IDX_BITS  = $clog2(DEPTH);
  localparam int CNT_BITS  = $clog2(DEPTH + 1);

  localparam int IN_FIELDS  = PID_BITS + PRIO_BITS;
  localparam int IN_W       = ((IN_FIELDS + 7) / 8) * 8;
  localparam int OUT_FIELDS = PID_BITS + 2 + CNT_BITS;
  localparam int OUT_W      = ((OUT_FIELDS + 7) / 8) * 8;

  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  typedef struct packed {
    logic load;
    logic step;
    logic commit;
  } prq_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } prq_sts_t;

endpackage

// ===== rtl/core/prq_ctrl.sv =====
module prq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  prq_pkg::prq_sts_t sts,
  output prq_pkg::prq_cmd_t cmd
);
  import prq_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } state_t;

  state_t state_r;

  assign in_tready  = (state_r == ST_IDLE);
  assign cmd.load   = in_tvalid && (state_r == ST_IDLE);
  assign cmd.step   = (state_r == ST_SCAN) && !sts.scan_done;
  assign cmd.commit = (state_r == ST_COMMIT) && sts.out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_tvalid) state_r <= ST_SCAN;
        end
        ST_SCAN: begin
          if (sts.scan_done) state_r <= ST_COMMIT;
        end
        ST_COMMIT: begin
          if (sts.out_free) state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/prq_datapath.sv =====
`include "priority_ready_queue_defines.svh"

module prq_datapath (
  input  logic                       clk,
  input  logic                       rst_n,
  input  prq_pkg::prq_cmd_t          cmd,
  output prq_pkg::prq_sts_t          sts,
  input  logic [prq_pkg::IN_W-1:0]   in_tdata,
  input  logic                       in_tuser,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [prq_pkg::OUT_W-1:0]  out_tdata
);
  import prq_pkg::*;

  logic [PID_BITS-1:0]  slot_pid_r  [DEPTH];
  logic [PRIO_BITS-1:0] slot_prio_r [DEPTH];
  logic [CNT_BITS-1:0]  cnt_r;
  logic [IDX_BITS-1:0]  pos_r;
  logic                 item_cmd_r;
  logic [PID_BITS-1:0]  item_pid_r;
  logic [PRIO_BITS-1:0] item_prio_r;
  logic                 out_tvalid_r;
  logic [OUT_W-1:0]     out_tdata_r;

  logic                 full;
  logic                 empty;
  logic                 at_end;
  logic                 enq_ok;
  logic                 deq_ok;
  logic [CNT_BITS-1:0]  cnt_nxt;
  logic [PID_BITS-1:0]  res_pid;

  assign full   = (cnt_r == CNT_BITS'(DEPTH));
  assign empty  = (cnt_r == '0);
  assign at_end = (CNT_BITS'(pos_r) == cnt_r);

  assign sts.scan_done = (item_cmd_r == CMD_DEQ) || full || at_end ||
                         (slot_prio_r[pos_r] < item_prio_r);
  assign sts.out_free  = !out_tvalid_r || out_tready;

  assign enq_ok = (item_cmd_r == CMD_ENQ) && !full;
  assign deq_ok = (item_cmd_r == CMD_DEQ) && !empty;

  always_comb begin
    cnt_nxt = cnt_r;
    if (enq_ok) cnt_nxt = cnt_r + 1'b1;
    else if (deq_ok) cnt_nxt = cnt_r - 1'b1;
  end

  assign res_pid = deq_ok ? slot_pid_r[0] : '0;

  // Item capture and walk position
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_cmd_r  <= in_tuser;
      item_pid_r  <= in_tdata[PID_BITS-1:0];
      item_prio_r <= in_tdata[PID_BITS +: PRIO_BITS];
      pos_r       <= '0;
    end else if (cmd.step) begin
      pos_r <= pos_r + 1'b1;
    end
  end

  // Slot row: insert opens a gap at pos, dequeue shifts toward the head
  always_ff @(posedge clk) begin
    if (cmd.commit && enq_ok) begin
      for (int k = 0; k < DEPTH; k++) begin
        if (IDX_BITS'(k) == pos_r) begin
          slot_pid_r[k]  <= item_pid_r;
          slot_prio_r[k] <= item_prio_r;
        end else if (k > 0 && IDX_BITS'(k) > pos_r) begin
          slot_pid_r[k]  <= slot_pid_r[k-1];
          slot_prio_r[k] <= slot_prio_r[k-1];
        end
      end
    end else if (cmd.commit && deq_ok) begin
      for (int k = 0; k < DEPTH - 1; k++) begin
        slot_pid_r[k]  <= slot_pid_r[k+1];
        slot_prio_r[k] <= slot_prio_r[k+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cmd.commit) begin
        cnt_r        <= cnt_nxt;
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_tdata_r <= OUT_W'({cnt_nxt,
                             (item_cmd_r == CMD_ENQ) && full,
                             deq_ok,
                             res_pid});
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  `PRQ_ASSERT(a_cnt_bound, cnt_r <= CNT_BITS'(DEPTH), "entry count above depth")
  `PRQ_ASSERT(a_commit_free, cmd.commit |-> sts.out_free, "commit while result held")
  `PRQ_ASSERT(a_deq_count, (cmd.commit && deq_ok) |=> (cnt_r == $past(cnt_r) - 1'b1), "dequeue count")
  `PRQ_ASSERT(a_walk_bound, cmd.step |-> (CNT_BITS'(pos_r) < cnt_r), "walk past last entry")

endmodule

// ===== rtl/core/priority_ready_queue.sv =====
// Flow: a transfer is captured in IDLE; SCAN then walks the stored entries of greater or
//   equal priority, one stored slot per cycle (a dequeue or a full queue skips the walk);
//   COMMIT then writes the result once the result register is free. A new item is taken
//   only after the last one commits; the result register lets it in while a result waits.
// Reset: entry count, controller state and result valid clear; slot contents are kept.
module priority_ready_queue (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [prq_pkg::IN_W-1:0]   in_tdata,   // item_pid, item_priority, zero pad
  input  logic                       in_tuser,   // cmd
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [prq_pkg::OUT_W-1:0]  out_tdata   // out_pid, out_valid, rejected, occupancy, zero pad
);
  import prq_pkg::*;

  prq_cmd_t cmd;
  prq_sts_t sts;

  prq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  prq_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
